FILE: design/householder_vector_defines.svh
// ----------------------------------------------------------------------------
// householder_vector_defines.svh
// Assertion macros shared by the Householder vector block.
// ----------------------------------------------------------------------------
`ifndef HOUSEHOLDER_VECTOR_DEFINES_SVH
`define HOUSEHOLDER_VECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Condition must never hold outside reset.
`define HV_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Same-cycle implication.
`define HV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define HV_ASSERT_NEVER(lbl, cond, msg)
`define HV_ASSERT_IMP(lbl, ante, cons, msg)
`define HV_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/hv_pkg.sv
// ----------------------------------------------------------------------------
// hv_pkg
// Shared constants, types and helpers of the Householder vector block.
// ----------------------------------------------------------------------------
package hv_pkg;

  localparam int MAX_LENGTH = 64;
  localparam int IDX_W      = $clog2(MAX_LENGTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DATA_W     = 32;
  localparam int BETA_W     = 18;

  localparam logic [DATA_W-1:0] ONE_Q = 32'h0001_0000;
  localparam logic [BETA_W-1:0] TWO_Q = 18'h2_0000;

  // divider geometry: numerator left-aligned, one quotient bit per cycle
  localparam int NUM_W  = 80;
  localparam int DEN_W  = 64;
  localparam int STEP_W = 7;
  localparam logic [STEP_W-1:0] STEPS_M    = 7'd64;
  localparam logic [STEP_W-1:0] STEPS_BETA = 7'd80;
  localparam logic [STEP_W-1:0] STEPS_X    = 7'd48;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic acc;
    logic prep;
    logic sqrt_step;
    logic msel;
    logic mdiv_take;
    logic norm;
    logic square;
    logic bshift;
    logic bdiv_take;
    logic rd;
    logic scale;
    logic sdiv_take;
    logic out_take;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_q;
    logic sigma_zero;
    logic x0_pos;
    logic sqrt_done;
    logic div_done;
    logic norm_done;
    logic bsh_done;
    logic pass_thru;
    logic final_elem;
  } status_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [31:0] magnitude(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

endpackage

FILE: design/hv_in_if.sv
// ----------------------------------------------------------------------------
// hv_in_if
// Input channel: one vector element per item.
// ----------------------------------------------------------------------------
interface hv_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [hv_pkg::DATA_W-1:0]    sample;
  logic                                last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: design/hv_out_if.sv
// ----------------------------------------------------------------------------
// hv_out_if
// Output channel: one Householder vector element per item.
// ----------------------------------------------------------------------------
interface hv_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [hv_pkg::DATA_W-1:0]    v_element;
  logic        [hv_pkg::BETA_W-1:0]    beta;
  logic        [hv_pkg::IDX_W-1:0]     position;
  logic                                final_res;

  modport source (output valid, output v_element, output beta, output position,
                  output final_res, input ready);
  modport sink   (input valid, input v_element, input beta, input position,
                  input final_res, output ready);
endinterface

FILE: design/hv_div.sv
// ----------------------------------------------------------------------------
// hv_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hv_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hv_pkg::NUM_W-1:0]   num,
  input  logic [hv_pkg::DEN_W-1:0]   den,
  input  logic [hv_pkg::STEP_W-1:0]  steps,
  output logic                       done,
  output logic [hv_pkg::DEN_W-1:0]   quo
);

  logic                       busy;
  logic [hv_pkg::STEP_W-1:0]  cnt;
  logic [hv_pkg::DEN_W-1:0]   rem;
  logic [hv_pkg::DEN_W-1:0]   den_q;
  logic [hv_pkg::NUM_W-1:0]   nsh;
  logic [hv_pkg::DEN_W:0]     trial;
  logic [hv_pkg::DEN_W:0]     diff;
  logic                       fits;

  assign trial = {rem, nsh[hv_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == hv_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      nsh   <= num;
      quo   <= '0;
      den_q <= den;
    end else if (busy) begin
      nsh <= nsh << 1;
      if (fits) begin
        rem <= diff[hv_pkg::DEN_W-1:0];
        quo <= {quo[hv_pkg::DEN_W-2:0], 1'b1};
      end else begin
        rem <= trial[hv_pkg::DEN_W-1:0];
        quo <= {quo[hv_pkg::DEN_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: design/hv_datapath.sv
// ----------------------------------------------------------------------------
// hv_datapath
// Element store, sum of squares, square root, beta and scaling datapath.
// ----------------------------------------------------------------------------
module hv_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  hv_pkg::cmd_t                      cmd,
  output hv_pkg::status_t                   st,
  input  logic signed [hv_pkg::DATA_W-1:0]  sample,
  input  logic                              last,
  output logic signed [hv_pkg::DATA_W-1:0]  v_element,
  output logic [hv_pkg::BETA_W-1:0]         beta,
  output logic [hv_pkg::IDX_W-1:0]          position,
  output logic                              final_res
);

  logic signed [hv_pkg::DATA_W-1:0] mem [hv_pkg::MAX_LENGTH];
  logic signed [hv_pkg::DATA_W-1:0] rd_data;
  logic [hv_pkg::CNT_W-1:0]         count;
  logic [63:0]                      sigma;
  logic signed [hv_pkg::DATA_W-1:0] x0;
  logic [63:0]                      x0sq;
  logic [63:0]                      sq;
  logic                             sq_use;
  logic                             sq_first;
  logic                             last_q;
  logic [63:0]                      rem_s;
  logic [63:0]                      root;
  logic [63:0]                      sbit;
  logic [33:0]                      m;
  logic [33:0]                      mwork;
  logic [1:0]                       shifts;
  logic [61:0]                      a;
  logic [63:0]                      b;
  logic [hv_pkg::IDX_W-1:0]         idx;

  logic [31:0]                      mx_in;
  logic [31:0]                      mx0;
  logic [31:0]                      mx_rd;
  logic [33:0]                      msum;
  logic [63:0]                      root_trial;
  logic                             div_start;
  logic [hv_pkg::NUM_W-1:0]         div_num;
  logic [hv_pkg::DEN_W-1:0]         div_den;
  logic [hv_pkg::STEP_W-1:0]        div_steps;
  logic                             div_done;
  logic [hv_pkg::DEN_W-1:0]         quo;

  assign mx_in      = hv_pkg::magnitude(sample);
  assign mx0        = hv_pkg::magnitude(x0);
  assign mx_rd      = hv_pkg::magnitude(rd_data);
  assign msum       = {2'b00, mx0} + {2'b00, root[31:0]};
  assign root_trial = root + sbit;

  assign st.last_q     = last_q;
  assign st.sigma_zero = (sigma == '0);
  assign st.x0_pos     = !x0[hv_pkg::DATA_W-1] && (x0 != '0);
  assign st.sqrt_done  = (sbit == '0);
  assign st.div_done   = div_done;
  assign st.norm_done  = (mwork[33:31] == 3'b000);
  assign st.bsh_done   = (b[63:62] == 2'b00);
  assign st.pass_thru  = (idx == '0) || (sigma == '0);
  assign st.final_elem = ({1'b0, idx} + hv_pkg::CNT_W'(1)) == count;

  assign position  = idx;
  assign final_res = st.final_elem;

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = {sigma, 16'h0000};
    div_den   = {30'd0, msum};
    div_steps = hv_pkg::STEPS_M;
    if (cmd.msel && st.x0_pos) begin
      div_start = 1'b1;
    end else if (cmd.bshift && st.bsh_done) begin
      div_start = 1'b1;
      div_num   = {1'b0, a, 17'd0};
      div_den   = {2'b00, a} + b;
      div_steps = hv_pkg::STEPS_BETA;
    end else if (cmd.scale && !st.pass_thru) begin
      div_start = 1'b1;
      div_num   = {mx_rd, 48'd0};
      div_den   = {30'd0, m};
      div_steps = hv_pkg::STEPS_X;
    end
  end

  hv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .done  (div_done),
    .quo   (quo)
  );

  // element store
  always_ff @(posedge clk) begin
    if (cmd.load && !count[hv_pkg::CNT_W-1]) begin
      mem[count[hv_pkg::IDX_W-1:0]] <= sample;
    end
    if (cmd.rd) begin
      rd_data <= mem[idx];
    end
  end

  // control state: count, sigma, index
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      sigma  <= '0;
      idx    <= '0;
      sq_use <= 1'b0;
      last_q <= 1'b0;
    end else begin
      if (cmd.load) begin
        last_q <= last;
        sq_use <= !count[hv_pkg::CNT_W-1];
        if (!count[hv_pkg::CNT_W-1]) begin
          count <= count + 1'b1;
        end
      end
      if (cmd.acc && sq_use && !sq_first) begin
        sigma <= hv_pkg::sat_add(sigma, sq);
      end
      if (cmd.prep) begin
        idx <= '0;
      end
      if (cmd.out_take) begin
        if (st.final_elem) begin
          count <= '0;
          sigma <= '0;
          idx   <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // arithmetic payload
  always_ff @(posedge clk) begin
    if (cmd.load && !count[hv_pkg::CNT_W-1]) begin
      sq       <= {32'd0, mx_in} * {32'd0, mx_in};
      sq_first <= (count == '0);
      if (count == '0) begin
        x0 <= sample;
      end
    end
    if (cmd.acc && sq_use && sq_first) begin
      x0sq <= sq;
    end
    if (cmd.prep) begin
      if (st.sigma_zero) begin
        beta <= (count == hv_pkg::CNT_W'(1) && x0[hv_pkg::DATA_W-1]) ? hv_pkg::TWO_Q : '0;
      end
      rem_s <= hv_pkg::sat_add(x0sq, sigma);
      root  <= '0;
      sbit  <= 64'h4000_0000_0000_0000;
    end
    if (cmd.sqrt_step && sbit != '0) begin
      if (rem_s >= root_trial) begin
        rem_s <= rem_s - root_trial;
        root  <= (root >> 1) + sbit;
      end else begin
        root <= root >> 1;
      end
      sbit <= sbit >> 2;
    end
    if (cmd.msel && !st.x0_pos) begin
      m      <= (msum == '0) ? 34'd1 : msum;
      mwork  <= (msum == '0) ? 34'd1 : msum;
      shifts <= '0;
    end
    if (cmd.mdiv_take) begin
      m      <= (quo == '0) ? 34'd1 : quo[33:0];
      mwork  <= (quo == '0) ? 34'd1 : quo[33:0];
      shifts <= '0;
    end
    if (cmd.norm && !st.norm_done) begin
      mwork  <= mwork >> 1;
      shifts <= shifts + 1'b1;
    end
    if (cmd.square) begin
      a <= {31'd0, mwork[30:0]} * {31'd0, mwork[30:0]};
      b <= sigma >> {shifts, 1'b0};
    end
    if (cmd.bshift && !st.bsh_done) begin
      a <= a >> 2;
      b <= b >> 2;
    end
    if (cmd.bdiv_take) begin
      beta <= quo[hv_pkg::BETA_W-1:0];
    end
    if (cmd.scale && st.pass_thru) begin
      v_element <= (idx == '0) ? $signed(hv_pkg::ONE_Q) : rd_data;
    end
    if (cmd.sdiv_take) begin
      if (!rd_data[hv_pkg::DATA_W-1]) begin
        // positive element: result negative
        v_element <= (quo >= 64'h8000_0000) ? 32'sh8000_0000 : $signed(32'(-quo[31:0]));
      end else begin
        v_element <= (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
      end
    end
  end

endmodule

FILE: design/hv_ctrl.sv
// ----------------------------------------------------------------------------
// hv_ctrl
// Sequencer for load, closing computation and emit phases.
// ----------------------------------------------------------------------------
module hv_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  hv_pkg::status_t  st,
  output hv_pkg::cmd_t     cmd
);

  typedef enum logic [13:0] {
    S_LOAD  = 14'b00000000000001,
    S_ACC   = 14'b00000000000010,
    S_PREP  = 14'b00000000000100,
    S_SQRT  = 14'b00000000001000,
    S_MSEL  = 14'b00000000010000,
    S_MDIV  = 14'b00000000100000,
    S_NORM  = 14'b00000001000000,
    S_SQ    = 14'b00000010000000,
    S_BSH   = 14'b00000100000000,
    S_BDIV  = 14'b00001000000000,
    S_RD    = 14'b00010000000000,
    S_SCALE = 14'b00100000000000,
    S_SDIV  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = st.last_q ? S_PREP : S_LOAD;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = st.sigma_zero ? S_RD : S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (st.sqrt_done) state_next = S_MSEL;
      end
      S_MSEL: begin
        cmd.msel   = 1'b1;
        state_next = st.x0_pos ? S_MDIV : S_NORM;
      end
      S_MDIV: begin
        if (st.div_done) begin
          cmd.mdiv_take = 1'b1;
          state_next    = S_NORM;
        end
      end
      S_NORM: begin
        cmd.norm = 1'b1;
        if (st.norm_done) state_next = S_SQ;
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_next = S_BSH;
      end
      S_BSH: begin
        cmd.bshift = 1'b1;
        if (st.bsh_done) state_next = S_BDIV;
      end
      S_BDIV: begin
        if (st.div_done) begin
          cmd.bdiv_take = 1'b1;
          state_next    = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = st.pass_thru ? S_OUT : S_SDIV;
      end
      S_SDIV: begin
        if (st.div_done) begin
          cmd.sdiv_take = 1'b1;
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.out_take = 1'b1;
          state_next   = st.final_elem ? S_LOAD : S_RD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/householder_vector.sv
// ----------------------------------------------------------------------------
// householder_vector
// Householder reflection vector over a streamed Q16.16 vector.
// ----------------------------------------------------------------------------
// Usage:
//   x_in  carries one element of x per item (sample, last). The item with
//         last set closes the vector; up to 64 elements are stored, later
//         ones are dropped but their last mark still closes the run.
//   v_out carries one item per stored element: v_element, beta (same in
//         every item), position and final_res on the last one.
// Loading: each item is squared in the load state and accumulated in the
//   accumulate state, so items are not taken back to back.
// After the last item: if sigma is zero the block goes straight to emit;
//   otherwise it runs the square root (one bit per cycle), select, divide
//   (only for x0 > 0), normalize, square, beta prescale and beta divide.
// Emit: each element is read, then passed through or scaled by the shared
//   one-bit-per-cycle divider; a stalled receiver holds the item in the
//   output register and the block waits.
// Reset clears the element count, sigma and the sequencer; the element
//   store needs no clearing. No input is taken until the run is emitted.
// ----------------------------------------------------------------------------
`include "householder_vector_defines.svh"

module householder_vector (
  input  logic          clk,
  input  logic          rst,
  hv_in_if.sink         x_in,
  hv_out_if.source      v_out
);

  hv_pkg::cmd_t    cmd;
  hv_pkg::status_t st;

  // sequencer: in_ready only in the load state, out_valid only in emit
  hv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (x_in.valid),
    .in_ready  (x_in.ready),
    .out_valid (v_out.valid),
    .out_ready (v_out.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // store, sigma, sqrt, beta and the shared divider
  hv_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .sample    (x_in.sample),
    .last      (x_in.last),
    .v_element (v_out.v_element),
    .beta      (v_out.beta),
    .position  (v_out.position),
    .final_res (v_out.final_res)
  );

  // load and emit phases never overlap
  `HV_ASSERT_NEVER(a_phase_excl, x_in.ready && v_out.valid, "input and output both active")
  // every accepted item takes an accumulate cycle
  `HV_ASSERT_NEXT(a_two_cycle, x_in.valid && x_in.ready, !x_in.ready, "item accepted back to back")
  // beta stays within 0..2
  `HV_ASSERT_IMP(a_beta_range, v_out.valid, v_out.beta <= hv_pkg::TWO_Q, "beta above 2.0")

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for householder_vector: streams vectors of Q16.16
// elements with random gaps, predicts the Householder vector and beta for
// each closed vector, and checks every output item in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 4000;  // cycles with no handshake at all
  localparam int DRAIN_WAIT  = 300;   // extra wait after both queues have drained
  localparam int ITEM_TARGET = 480;
  localparam int PRINT_CAP   = 40;

  typedef struct {
    logic signed [hv_pkg::DATA_W-1:0] sample;
    logic                             last;
  } element_item_t;

  typedef struct {
    logic [hv_pkg::DATA_W-1:0] v_element;
    logic [hv_pkg::BETA_W-1:0] beta;
    logic [hv_pkg::IDX_W-1:0]  position;
    logic                      final_res;
  } reflector_item_t;

  logic clk;
  logic rst;

  hv_in_if  x_in ();
  hv_out_if v_out ();

  householder_vector u_top (
    .clk   (clk),
    .rst   (rst),
    .x_in  (x_in),
    .v_out (v_out)
  );

  element_item_t   element_queue[$];   // items waiting for the driver
  reflector_item_t reflector_queue[$]; // predicted output items, oldest first

  // predictor state, mirrors the block's load phase
  logic signed [hv_pkg::DATA_W-1:0] vec_store [hv_pkg::MAX_LENGTH];
  int unsigned                      vec_count;
  logic [63:0]                      sigma_acc;

  int  errors;
  int  idle_cycles;
  int  in_gap;
  int  out_stall;
  int  accepted_items;
  bit  gaps_off;   // stretch with no idling on either side

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // known values before the first edge
  initial begin
    x_in.valid  = 1'b0;
    x_in.sample = '0;
    x_in.last   = 1'b0;
    v_out.ready = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("%0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  function automatic int draw_wait();
    if (gaps_off) return 0;
    return $urandom_range(0, 4);
  endfunction

  function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic logic [63:0] abs_of(input logic signed [hv_pkg::DATA_W-1:0] x);
    logic signed [63:0] w;
    w = x;
    return (w < 0) ? -w : w;
  endfunction

  // floor square root, one result bit at a time from the top
  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [hv_pkg::BETA_W-1:0] beta_of(input logic [63:0] m,
                                                        input logic [63:0] sigma);
    int          s;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
    logic [81:0] q;
    s = 0;
    while ((m >> 31) != 0) begin
      m = m >> 1;
      s++;
    end
    a = m * m;
    b = sigma >> (2 * s);
    while (b >= (64'd1 << 62)) begin
      a = a >> 2;
      b = b >> 2;
    end
    d = a + b;
    if (d == 0) return '0;
    q = ({18'd0, a} << 17) / {18'd0, d};
    return q[hv_pkg::BETA_W-1:0];
  endfunction

  // x * 2^16 / -m, toward zero, clamped to signed 32 bits
  function automatic logic [hv_pkg::DATA_W-1:0] scaled_of(
      input logic signed [hv_pkg::DATA_W-1:0] x, input logic [63:0] m);
    logic [63:0] q;
    q = (abs_of(x) << 16) / m;
    if (x > 0) begin
      if (q >= 64'h8000_0000) return 32'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[hv_pkg::DATA_W-1:0];
  endfunction

  // one accepted element; a last mark closes the vector and queues its outputs
  task automatic predict_reflector(input logic signed [hv_pkg::DATA_W-1:0] x,
                                   input logic last);
    logic [63:0]               sigma;
    logic [63:0]               m;
    logic [63:0]               mx0;
    logic [63:0]               mu;
    logic [hv_pkg::BETA_W-1:0] beta;
    reflector_item_t           r;
    int unsigned               n;
    m = 0;
    if (vec_count < hv_pkg::MAX_LENGTH) begin
      vec_store[vec_count] = x;
      if (vec_count > 0) sigma_acc = add_clamped(sigma_acc, abs_of(x) * abs_of(x));
      vec_count++;
    end
    if (!last) return;
    n     = vec_count;
    sigma = sigma_acc;
    if (sigma == 0) begin
      beta = (n == 1 && vec_store[0] < 0) ? hv_pkg::TWO_Q : '0;
    end else begin
      mx0 = abs_of(vec_store[0]);
      mu  = root_floor(add_clamped(mx0 * mx0, sigma));
      m   = (vec_store[0] <= 0) ? mx0 + mu : sigma / (mx0 + mu);
      if (m == 0) m = 1;  // tiny v0 floors at one LSB
      beta = beta_of(m, sigma);
    end
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0)          r.v_element = hv_pkg::ONE_Q;
      else if (sigma == 0) r.v_element = vec_store[i];
      else                 r.v_element = scaled_of(vec_store[i], m);
      r.beta      = beta;
      r.position  = i[hv_pkg::IDX_W-1:0];
      r.final_res = (i + 1 == n);
      reflector_queue.push_back(r);
    end
    vec_count = 0;
    sigma_acc = '0;
  endtask

  // driver: a random gap after each item, none while gaps are off
  always @(posedge clk) begin
    element_item_t it;
    if (rst) begin
      x_in.valid <= 1'b0;
      in_gap     <= 0;
    end else begin
      if (x_in.valid && x_in.ready) begin
        predict_reflector(x_in.sample, x_in.last);
        accepted_items++;
      end
      if (!x_in.valid || x_in.ready) begin
        if (in_gap > 0) begin
          in_gap     <= in_gap - 1;
          x_in.valid <= 1'b0;
        end else if (element_queue.size() > 0) begin
          it          = element_queue.pop_front();
          x_in.sample <= it.sample;
          x_in.last   <= it.last;
          x_in.valid  <= 1'b1;
          in_gap      <= draw_wait();
          if ($urandom_range(0, 29) == 0) gaps_off = !gaps_off;
        end else begin
          x_in.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each output item with the oldest prediction, then stall
  always @(posedge clk) begin
    reflector_item_t want;
    int              n;
    if (rst) begin
      v_out.ready <= 1'b0;
      out_stall   <= 0;
    end else if (v_out.valid && v_out.ready) begin
      if (reflector_queue.size() == 0) begin
        report_mismatch("unexpected item, position", v_out.position, 0);
      end else begin
        want = reflector_queue.pop_front();
        if (v_out.v_element !== want.v_element)
          report_mismatch("v_element", v_out.v_element, want.v_element);
        if (v_out.beta !== want.beta)
          report_mismatch("beta", v_out.beta, want.beta);
        if (v_out.position !== want.position)
          report_mismatch("position", v_out.position, want.position);
        if (v_out.final_res !== want.final_res)
          report_mismatch("final_res", v_out.final_res, want.final_res);
      end
      n = draw_wait();
      out_stall   <= n;
      v_out.ready <= (n == 0);
    end else if (out_stall > 0) begin
      out_stall   <= out_stall - 1;
      v_out.ready <= (out_stall == 1);
    end else begin
      v_out.ready <= 1'b1;
    end
  end

  // watchdog on progress of either channel
  always @(posedge clk) begin
    if (rst || (x_in.valid && x_in.ready) || (v_out.valid && v_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  int queued_items;

  function automatic logic signed [hv_pkg::DATA_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
      7:          return '0;
      8:          return 32'sh8000_0000;
      default:    return 32'sh7FFF_FFFF;
    endcase
  endfunction

  task automatic queue_vector(input logic signed [hv_pkg::DATA_W-1:0] xs[$]);
    element_item_t it;
    foreach (xs[i]) begin
      it.sample = xs[i];
      it.last   = (i == xs.size() - 1);
      element_queue.push_back(it);
      queued_items++;
    end
  endtask

  initial begin
    logic signed [hv_pkg::DATA_W-1:0] xs[$];
    int                               len;
    errors         = 0;
    queued_items   = 0;
    accepted_items = 0;
    vec_count      = 0;
    sigma_acc      = '0;
    gaps_off       = 1'b0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: single elements of each sign, zero and the most negative value
    queue_vector('{32'sh0005_0000});
    queue_vector('{-32'sh0003_0000});   // beta of 2
    queue_vector('{32'sh0});
    queue_vector('{32'sh8000_0000});
    // large positive x0 against a tiny tail: v0 collapses to one LSB
    queue_vector('{32'sh7FFF_FFFF, 32'sh1});
    // zero tail passes x through unscaled
    queue_vector('{32'sh0002_0000, 32'sh0, 32'sh0});
    queue_vector('{-32'sh0001_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
    queue_vector('{32'sh0, 32'sh0003_0000});
    queue_vector('{32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000});
    queue_vector('{32'sh8000_0000, 32'sh1});

    // hold off until the directed vectors have fully drained
    do @(posedge clk);
    while (accepted_items < queued_items || reflector_queue.size() > 0);

    // overlong run of minimum values: sum of squares clamps, extras dropped
    xs = {};
    repeat (hv_pkg::MAX_LENGTH + 2) xs.push_back(32'sh8000_0000);
    queue_vector(xs);

    while (queued_items < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(hv_pkg::MAX_LENGTH - 4, hv_pkg::MAX_LENGTH + 6);
        1, 2, 3: len = 1;
        default: len = $urandom_range(2, 8);
      endcase
      xs = {};
      repeat (len) xs.push_back(random_sample());
      queue_vector(xs);
    end

    do @(posedge clk);
    while (accepted_items < queued_items || reflector_queue.size() > 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0 && reflector_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
